@@ design/sts_pkg.sv @@
// Shared constants, codes and the command type of the suffix-sum tree.
// No dependencies; every other design file depends on this package.
package sts_pkg;

    // Tree geometry: heap order, root is node 0, leaf i is node LEAVES-1+i
    localparam int LEAVES = 1024;
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int NODE_W = $clog2(NODES);

    // Field widths
    localparam int VAL_W = 32;
    localparam int SUM_W = 42;

    // Command queue between front and back (power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic
    {
        OP_ASSIGN = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } st_t;

    // Classified command: leaf node already resolved, value already widened
    typedef struct packed
    {
        op_t               op;
        logic [NODE_W-1:0] node;
        logic [SUM_W-1:0]  value;
    } cmd_t;

endpackage

@@ design/sts_in_if.sv @@
// Request channel: valid/ready handshake carrying one tree operation.
// Depends on sts_pkg for the field widths.
interface sts_in_if;

    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [sts_pkg::LEAF_W-1:0]         leaf_index;
    logic signed [sts_pkg::VAL_W-1:0]   leaf_value;

    modport source (output valid, func, leaf_index, leaf_value, input ready);
    modport sink   (input valid, func, leaf_index, leaf_value, output ready);

endinterface

@@ design/sts_out_if.sv @@
// Response channel: valid/ready handshake carrying one suffix sum.
// Depends on sts_pkg for the field width.
interface sts_out_if;

    logic                               valid;
    logic                               ready;
    logic signed [sts_pkg::SUM_W-1:0]   suffix_sum;

    modport source (output valid, suffix_sum, input ready);
    modport sink   (input valid, suffix_sum, output ready);

endinterface

@@ design/segment_tree_suffix_sum.sv @@
// Top level of the point-assign / suffix-sum segment tree.
// Depends on sts_pkg, sts_in_if, sts_out_if, sts_front, sts_queue, sts_back.
//
//   channel  role    payload                               transaction
//   req      sink    func, leaf_index, leaf_value          one assign or query
//   rsp      source  suffix_sum                            one query result
//
// In the walker, an assign or a query climbs one tree level per step, with one
// sibling read of the node-sum memory per level; a query then loads its result.
// After reset a clearing pass writes zero to all NODES (2047) entries, one per
// cycle, and req.ready stays low until it ends.
// A stalled rsp holds the walker only when a second result is ready; the
// command queue keeps taking requests while it has room.
module segment_tree_suffix_sum
(
    input logic     clk,
    input logic     rst_n,
    sts_in_if.sink  req,
    sts_out_if.source rsp
);
    import sts_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    logic clear_done;

    sts_front u_front
    (
        .req        (req),
        .clear_done (clear_done),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    sts_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    sts_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .clear_done (clear_done),
        .rsp        (rsp)
    );

endmodule

@@ design/sts_front.sv @@
// Front end: accepts request transactions and turns them into commands.
// Depends on sts_pkg and sts_in_if.
module sts_front
(
    sts_in_if.sink          req,
    input  logic            clear_done,
    output sts_pkg::cmd_t   push_cmd,
    output logic            push_valid,
    input  logic            push_ready
);
    import sts_pkg::*;

    localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(LEAVES - 1);

    op_t op;

    // No transactions until the tree memory has been cleared
    assign req.ready  = push_ready && clear_done;
    assign push_valid = req.valid && clear_done;

    // Decode: leaf node number, and a widened value (zero for queries so the
    // back end can seed its accumulator from the same field)
    always_comb
    begin
        op            = op_t'(req.func);
        push_cmd.op   = op;
        push_cmd.node = LEAF_BASE + NODE_W'(req.leaf_index);
        if (op == OP_QUERY)
        begin
            push_cmd.value = '0;
        end
        else
        begin
            push_cmd.value = {{(SUM_W - VAL_W){req.leaf_value[VAL_W-1]}}, req.leaf_value};
        end
    end

endmodule

@@ design/sts_queue.sv @@
// Small command FIFO that decouples the front end from the tree walker.
// Depends on sts_pkg.
module sts_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  sts_pkg::cmd_t   push_cmd,
    input  logic            push_valid,
    output logic            push_ready,
    output sts_pkg::cmd_t   pop_cmd,
    output logic            pop_valid,
    input  logic            pop_ready
);
    import sts_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/sts_back.sv @@
// Back end: node-sum memory, clearing pass, and the leaf-to-root walker.
// Depends on sts_pkg and sts_out_if.
module sts_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  sts_pkg::cmd_t   pop_cmd,
    input  logic            pop_valid,
    output logic            pop_ready,
    output logic            clear_done,
    sts_out_if.source       rsp
);
    import sts_pkg::*;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    function automatic logic [NODE_W-1:0] sibling(input logic [NODE_W-1:0] n);
        return n[0] ? n + 1'b1 : n - 1'b1;
    endfunction

    function automatic logic [NODE_W-1:0] parent(input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] m;
        m = n - 1'b1;
        return m >> 1;
    endfunction

    st_t               state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    op_t               op_reg, op_next;
    logic [NODE_W-1:0] clr_addr_reg, clr_addr_next;
    logic              res_valid_reg, res_valid_next;
    logic [SUM_W-1:0]  res_sum_reg;
    logic [SUM_W-1:0]  rdata_reg;

    logic [SUM_W-1:0]  sum_mem [NODES];

    logic              mem_we, mem_re;
    logic [NODE_W-1:0] mem_waddr, mem_raddr;
    logic [SUM_W-1:0]  mem_wdata;
    logic [NODE_W-1:0] par;
    logic [SUM_W-1:0]  sum;
    logic              res_load;

    assign par        = parent(node_reg);
    assign sum        = acc_reg + rdata_reg;
    assign pop_ready  = state_reg == ST_IDLE;
    assign clear_done = state_reg != ST_CLEAR;
    assign res_load   = (state_reg == ST_RESULT) && (!res_valid_reg || rsp.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (par == '0)
                begin
                    state_next = (op_reg == OP_QUERY) ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath and memory port control
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = node_reg;
        mem_wdata     = sum;
        mem_re        = 1'b0;
        mem_raddr     = sibling(par);
        node_next     = node_reg;
        acc_next      = acc_reg;
        op_next       = op_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    // Leaf write on assign; fetch the leaf's sibling either way
                    mem_we    = pop_cmd.op == OP_ASSIGN;
                    mem_waddr = pop_cmd.node;
                    mem_wdata = pop_cmd.value;
                    mem_re    = 1'b1;
                    mem_raddr = sibling(pop_cmd.node);
                    node_next = pop_cmd.node;
                    acc_next  = pop_cmd.value;
                    op_next   = pop_cmd.op;
                end
            end
            ST_WALK:
            begin
                // One level per cycle: sibling data is ready, step to parent
                if (op_reg == OP_ASSIGN)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = par;
                    acc_next  = sum;
                end
                else if (node_reg[0])
                begin
                    // left child: the right sibling lies above the query index
                    acc_next = sum;
                end
                node_next = par;
                mem_re    = par != '0;
                mem_raddr = sibling(par);
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign rsp.valid      = res_valid_reg;
    assign rsp.suffix_sum = res_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Walker payload, no reset
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        acc_reg  <= acc_next;
        op_reg   <= op_next;
        if (res_load)
        begin
            res_sum_reg <= acc_reg;
        end
    end

    // Node-sum memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= sum_mem[mem_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("memory read and write hit the same node");

    a_walk_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> node_reg != '0)
        else $error("walker stepped above the root");

    a_walk_climbs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |=> node_reg < $past(node_reg))
        else $error("walker did not move toward the root");

    a_walk_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> $past(mem_re))
        else $error("walk step without a sibling read in flight");
`endif

endmodule

@@ sim/segment_tree_suffix_sum_checker.sv @@
// Checker for the suffix-sum tree: watches the req and rsp channels, keeps a
// shadow copy of the node sums and compares every suffix_sum transaction.
// Depends on sts_pkg, sts_in_if and sts_out_if.
`timescale 1ns / 100ps

module segment_tree_suffix_sum_checker
(
    input  logic clk,
    input  logic rst_n,
    sts_in_if    req,
    sts_out_if   rsp,
    output int   mismatches,
    output int   pending
);
    import sts_pkg::*;

    // Shadow tree in heap order, root at node 0, leaf i at node LEAVES-1+i
    logic [SUM_W-1:0]        tree_sums [NODES];
    logic signed [SUM_W-1:0] expected_sums [$];
    int                      error_count;

    // Write one leaf and rebuild the sums on its path to the root
    function automatic void write_leaf(input logic [LEAF_W-1:0] idx,
                                       input logic signed [VAL_W-1:0] value);
        int n;
        n = LEAVES - 1 + int'(idx);
        tree_sums[n] = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
        while (n > 0)
        begin
            n = (n - 1) / 2;
            tree_sums[n] = tree_sums[2*n+1] + tree_sums[2*n+2];
        end
    endfunction

    // Sum of the leaves above idx: every right sibling met on the way up
    function automatic logic [SUM_W-1:0] sum_above(input logic [LEAF_W-1:0] idx);
        int               n;
        logic [SUM_W-1:0] acc;
        n   = LEAVES - 1 + int'(idx);
        acc = '0;
        while (n > 0)
        begin
            if (n % 2 == 1)
                acc = acc + tree_sums[n+1];
            n = (n - 1) / 2;
        end
        return acc;
    endfunction

    function automatic void note_error();
        error_count++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SUM_W-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
                tree_sums[i] = '0;
            expected_sums.delete();
            error_count = 0;
            mismatches  <= 0;
            pending     <= 0;
        end
        else
        begin
            // Result transaction: check against the oldest open query
            if (rsp.valid && rsp.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    note_error();
                    if (error_count <= 10)
                        $display("%0t: unexpected suffix_sum %0d, no query open",
                                 $realtime, rsp.suffix_sum);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (rsp.suffix_sum !== want)
                    begin
                        note_error();
                        if (error_count <= 10)
                            $display("%0t: suffix_sum expected %0d, got %0d",
                                     $realtime, want, rsp.suffix_sum);
                    end
                end
            end

            // Request transaction: update the shadow tree or queue a sum
            if (req.valid && req.ready)
            begin
                if (req.func == OP_QUERY)
                    expected_sums.push_back(sum_above(req.leaf_index));
                else
                    write_leaf(req.leaf_index, req.leaf_value);
            end

            mismatches <= error_count;
            pending    <= expected_sums.size();
        end
    end

endmodule

@@ sim/segment_tree_suffix_sum_test.sv @@
// Testbench top for segment_tree_suffix_sum: drives directed and random
// assign/query transactions with random stalls and gives the verdict.
// Depends on sts_pkg, both channel interfaces, the checker module and segment_tree_suffix_sum.
`timescale 1ns / 100ps

module segment_tree_suffix_sum_test;

    import sts_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int SEGMENT      = 150;
    localparam int QUIET_TAIL   = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n;
    int   idle_mode;
    int   mismatches;
    int   pending;
    int   cycle_count = 0;

    sts_in_if  req ();
    sts_out_if rsp ();

    segment_tree_suffix_sum DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    segment_tree_suffix_sum_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random bursts of backpressure, none in idle mode 0
    always
    begin
        @(negedge clk);
        if ((idle_mode == 1 && $urandom_range(0, 15) == 0) ||
            (idle_mode == 2 && $urandom_range(0, 2) == 0))
        begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        rsp.ready <= 1'b1;
    end

    // One request transaction; entered and left at a falling edge
    task automatic send_op(input op_t op, input logic [LEAF_W-1:0] idx,
                           input logic signed [VAL_W-1:0] value);
        if ((idle_mode == 1 && $urandom_range(0, 7) == 0) ||
            (idle_mode == 2 && $urandom_range(0, 1) == 0))
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.func       <= op;
        req.leaf_index <= idx;
        req.leaf_value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value(input bit extremes_only);
        case ($urandom_range(0, extremes_only ? 1 : 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LEAF_W-1:0] pick_index();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LEAF_W'(LEAVES - 1);
            2:       return LEAF_W'(LEAVES / 2 - 1);
            3:       return LEAF_W'(LEAVES / 2);
            default: return LEAF_W'($urandom_range(0, LEAVES - 1));
        endcase
    endfunction

    initial
    begin
        bit extremes_only;
        rst_n          = 1'b0;
        idle_mode      = 0;
        req.valid      = 1'b0;
        req.func       = OP_ASSIGN;
        req.leaf_index = '0;
        req.leaf_value = '0;
        extremes_only  = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty tree, field extremes, last leaf, overwrite
        send_op(OP_QUERY,  '0,                      $urandom);
        send_op(OP_QUERY,  LEAF_W'(LEAVES - 1),     $urandom);
        send_op(OP_ASSIGN, '0,                      VAL_MIN);
        send_op(OP_ASSIGN, LEAF_W'(LEAVES - 1),     VAL_MAX);
        send_op(OP_ASSIGN, LEAF_W'(LEAVES / 2 - 1), '1);
        send_op(OP_ASSIGN, LEAF_W'(LEAVES / 2),     VAL_W'(1));
        send_op(OP_ASSIGN, LEAF_W'(1),              32'sh5555_5555);
        send_op(OP_ASSIGN, LEAF_W'(LEAVES - 2),     32'shAAAA_AAAA);
        send_op(OP_QUERY,  '0,                      VAL_MAX);
        send_op(OP_QUERY,  LEAF_W'(1),              VAL_MIN);
        send_op(OP_QUERY,  LEAF_W'(LEAVES / 2 - 2), '0);
        send_op(OP_QUERY,  LEAF_W'(LEAVES / 2 - 1), '1);
        send_op(OP_QUERY,  LEAF_W'(LEAVES / 2),     $urandom);
        send_op(OP_QUERY,  LEAF_W'(LEAVES - 2),     $urandom);
        send_op(OP_QUERY,  LEAF_W'(LEAVES - 1),     $urandom);
        send_op(OP_ASSIGN, LEAF_W'(LEAVES - 1),     '0);
        send_op(OP_QUERY,  LEAF_W'(LEAVES - 2),     $urandom);
        send_op(OP_ASSIGN, '0,                      VAL_MAX);
        send_op(OP_QUERY,  '0,                      $urandom);
        send_op(OP_ASSIGN, LEAF_W'(LEAVES / 2),     VAL_MIN);
        send_op(OP_QUERY,  LEAF_W'(LEAVES / 2 - 1), $urandom);

        // Random: segments with their own idle mode and value style
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % SEGMENT == 0)
            begin
                idle_mode      = (i >= RANDOM_ITEMS - QUIET_TAIL) ? 0
                                 : int'($urandom_range(0, 2));
                extremes_only  = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 1) == 0)
                send_op(OP_ASSIGN, pick_index(), pick_value(extremes_only));
            else
                send_op(OP_QUERY, pick_index(), $urandom);
        end
        req.valid <= 1'b0;

        // Drain
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ segment_tree_suffix_sum.f @@
design/sts_pkg.sv
design/sts_in_if.sv
design/sts_out_if.sv
design/sts_front.sv
design/sts_queue.sv
design/sts_back.sv
design/segment_tree_suffix_sum.sv
sim/segment_tree_suffix_sum_checker.sv
sim/segment_tree_suffix_sum_test.sv
